// ===== rtl/ggnh_pkg.sv =====
// Shared types and constants for the greedy geographic next-hop selector.
package ggnh_pkg;

	localparam int ADDR_W  = 32;
	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int D2_W    = SQ_W;
	localparam int RSQ_W   = 2 * RAD_W;

	// 10000 m in Q15.8
	localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd2560000;

	// One neighbor entry, address in the low bits
	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
		logic [ADDR_W-1:0]         addr;
	} nbr_entry_t;

	typedef enum logic [1:0] {
		FUNC_BEACON = 2'd0,
		FUNC_CLEAR  = 2'd1,
		FUNC_COPY   = 2'd2,
		FUNC_QUERY  = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		CFG_SELF_ADDRESS  = 1'b0,
		CFG_SEARCH_RADIUS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BEACON,
		ST_COPY,
		ST_QUERY,
		ST_DONE
	} state_t;

	// Result leaving the distance unit
	typedef struct packed {
		logic              vld;
		logic              busy;
		logic [D2_W-1:0]   d2;
		logic [ADDR_W-1:0] tag;
	} dist_out_t;

endpackage

// ===== rtl/ggnh_ram.sv =====
// Simple dual-port table memory: one write port, one registered read port.
module ggnh_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ggnh_dist.sv =====
// Pipelined squared-distance unit: difference, square, sum.
module ggnh_dist (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  ggnh_pkg::nbr_entry_t                 nbr,
	input  logic signed [ggnh_pkg::COORD_W-1:0]  dest_x,
	input  logic signed [ggnh_pkg::COORD_W-1:0]  dest_y,
	output ggnh_pkg::dist_out_t                  res
);

	import ggnh_pkg::*;

	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [ADDR_W-1:0]        tag_s1, tag_s2, tag_s3;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2;
	logic [D2_W-1:0]          d2_s3;
	logic signed [SQ_W-1:0]   sqx, sqy;

	// track occupancy of each stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// exact signed differences
	always_ff @(posedge clk) begin
		dx_s1  <= DIFF_W'(nbr.x) - DIFF_W'(dest_x);
		dy_s1  <= DIFF_W'(nbr.y) - DIFF_W'(dest_y);
		tag_s1 <= nbr.addr;
	end

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;

	// squares, always non-negative
	always_ff @(posedge clk) begin
		sqx_s2 <= $unsigned(sqx);
		sqy_s2 <= $unsigned(sqy);
		tag_s2 <= tag_s1;
	end

	// sum fits since each square is at most 2^48
	always_ff @(posedge clk) begin
		d2_s3  <= sqx_s2 + sqy_s2;
		tag_s3 <= tag_s2;
	end

	assign res.vld  = vld_s3;
	assign res.busy = vld_s1 | vld_s2 | vld_s3;
	assign res.d2   = d2_s3;
	assign res.tag  = tag_s3;

endmodule

// ===== rtl/greedy_geographic_next_hop.sv =====
// Top level: neighbor tables, scan sequencer and nearest-neighbor selection.
//
//  channel  dir  handshake          payload
//  s        in   s_tvalid/s_tready  tdata {pos_y, pos_x, node_address}, tuser func
//  m        out  m_tvalid/m_tready  tdata next_hop, tuser found
//  cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Beacons and copies scan the fill table through its registered read port; a route
// query scans the active table and runs each entry through the three-stage distance
// pipeline. A fill count replaces per-entry valid bits, so reset needs no pass. Input
// is held off while an item is in work; a query result waits in the done state until
// the output is free.
module greedy_geographic_next_hop #(
	parameter int NEIGHBOR_SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [79:0]           s_tdata,   // node_address[31:0], pos_x[55:32], pos_y[79:56]
	input  logic [1:0]            s_tuser,   // func[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // next_hop[31:0]
	output logic [0:0]            m_tuser,   // found[0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  ggnh_pkg::cfg_reg_t    cfg_index,
	input  logic [31:0]           cfg_data
);

	import ggnh_pkg::*;

	localparam int IDX_W = $clog2(NEIGHBOR_SLOTS);
	localparam int CNT_W = $clog2(NEIGHBOR_SLOTS + 1);
	localparam int ENT_W = $bits(nbr_entry_t);
	localparam logic [CNT_W-1:0] SLOTS = CNT_W'(NEIGHBOR_SLOTS);

	state_t            state_q, state_d;
	nbr_entry_t        in_ent, item_q;
	func_t             in_func;
	logic              accept;

	logic [ADDR_W-1:0] self_q;
	logic [RAD_W-1:0]  radius_q;
	logic [RSQ_W-1:0]  r_sq_q;

	logic [CNT_W-1:0]  fill_count_q, active_count_q, scan_idx_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	logic              issue, beacon_hit, beacon_miss, copy_end, query_end, out_load;
	logic              fill_we, act_we, qualify;
	logic [IDX_W-1:0]  fill_waddr;
	nbr_entry_t        fill_rdata, act_rdata;
	logic [ENT_W-1:0]  fill_rraw, act_rraw;

	logic [D2_W-1:0]   best_q;
	logic [ADDR_W-1:0] hop_q;
	logic              hit_q;
	logic [ADDR_W-1:0] out_hop_q;
	logic              out_found_q, m_tvalid_q;
	dist_out_t         dist_res;

	assign in_ent   = nbr_entry_t'(s_tdata);
	assign in_func  = func_t'(s_tuser);
	assign accept   = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	assign fill_rdata = nbr_entry_t'(fill_rraw);
	assign act_rdata  = nbr_entry_t'(act_rraw);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q   <= '0;
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SELF_ADDRESS:  self_q   <= cfg_data;
				CFG_SEARCH_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// squared radius, registered from the radius register
	always_ff @(posedge clk) begin
		r_sq_q <= RSQ_W'(radius_q) * RSQ_W'(radius_q);
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_ent;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_func)
						FUNC_BEACON: if (in_ent.addr != self_q) state_d = ST_BEACON;
						FUNC_CLEAR:  state_d = ST_IDLE;
						FUNC_COPY:   state_d = ST_COPY;
						FUNC_QUERY:  state_d = ST_QUERY;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_BEACON: if (beacon_hit || beacon_miss) state_d = ST_IDLE;
			ST_COPY:   if (copy_end) state_d = ST_IDLE;
			ST_QUERY:  if (query_end) state_d = ST_DONE;
			ST_DONE:   if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready    = 1'b0;
		issue       = 1'b0;
		beacon_hit  = 1'b0;
		beacon_miss = 1'b0;
		copy_end    = 1'b0;
		query_end   = 1'b0;
		out_load    = 1'b0;
		act_we      = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_BEACON: begin
				issue       = scan_idx_q < fill_count_q;
				beacon_hit  = rd_vld_s1 && (fill_rdata.addr == item_q.addr);
				beacon_miss = !rd_vld_s1 && (scan_idx_q == fill_count_q);
			end
			ST_COPY: begin
				issue    = scan_idx_q < fill_count_q;
				act_we   = rd_vld_s1;
				copy_end = !rd_vld_s1 && (scan_idx_q == fill_count_q);
			end
			ST_QUERY: begin
				issue      = scan_idx_q < active_count_q;
				query_end  = !rd_vld_s1 && !dist_res.busy && (scan_idx_q == active_count_q);
			end
			ST_DONE: out_load = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// overwrite a matching entry, else append while room is left
	assign fill_we    = beacon_hit || (beacon_miss && (fill_count_q != SLOTS));
	assign fill_waddr = beacon_hit ? rd_idx_s1 : fill_count_q[IDX_W-1:0];

	// state, counters and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_count_q   <= '0;
			active_count_q <= '0;
			scan_idx_q     <= '0;
			rd_vld_s1      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (accept && in_func == FUNC_CLEAR) begin
				fill_count_q <= '0;
			end else if (beacon_miss && fill_count_q != SLOTS) begin
				fill_count_q <= fill_count_q + 1'b1;
			end
			if (copy_end) begin
				active_count_q <= fill_count_q;
			end
		end
	end

	// index of the slot whose data arrives next cycle
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
	end

	ggnh_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NEIGHBOR_SLOTS)
	) u_fill_ram (
		.clk  (clk),
		.we   (fill_we),
		.waddr(fill_waddr),
		.wdata(item_q),
		.raddr(scan_idx_q[IDX_W-1:0]),
		.rdata(fill_rraw)
	);

	ggnh_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NEIGHBOR_SLOTS)
	) u_active_ram (
		.clk  (clk),
		.we   (act_we),
		.waddr(rd_idx_s1),
		.wdata(fill_rraw),
		.raddr(scan_idx_q[IDX_W-1:0]),
		.rdata(act_rraw)
	);

	ggnh_dist u_dist (
		.clk   (clk),
		.arst_n(arst_n),
		.in_vld(rd_vld_s1 && state_q == ST_QUERY),
		.nbr   (act_rdata),
		.dest_x(item_q.x),
		.dest_y(item_q.y),
		.res   (dist_res)
	);

	// strictly inside the radius and strictly better than the best so far
	assign qualify = dist_res.vld && (dist_res.d2 < D2_W'(r_sq_q)) &&
		(!hit_q || dist_res.d2 < best_q);

	// running best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			hop_q <= '0;
		end else if (accept) begin
			hit_q <= 1'b0;
			hop_q <= '0;
		end else if (qualify) begin
			hit_q <= 1'b1;
			hop_q <= dist_res.tag;
		end
	end

	always_ff @(posedge clk) begin
		if (qualify) begin
			best_q <= dist_res.d2;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q  <= 1'b0;
			out_hop_q   <= '0;
			out_found_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q  <= 1'b1;
			out_hop_q   <= hop_q;
			out_found_q <= hit_q;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = out_hop_q;
	assign m_tuser[0] = out_found_q;

	// fill count never passes the table size
	assert property (@(posedge clk) disable iff (!arst_n) fill_count_q <= SLOTS)
		else $error("fill count beyond table size");

	// a result appears only out of the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	// the active count changes only at the end of a copy
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(active_count_q) |-> $past(state_q == ST_COPY))
		else $error("active count changed outside copy");

	// no neighbor found means a zero address
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("next hop nonzero without a hit");

endmodule
